// ===== rtl/buddy_block_allocator_macros.svh =====
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, reported on failure
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

// ===== rtl/bba_pkg.sv =====
// Types, constants and helpers for the buddy block allocator.
package bba_pkg;

  localparam int MIN_BLOCK    = 32;
  localparam int LEVELS       = 8;
  localparam int HEADER_BYTES = 8;

  localparam int MB_SH    = $clog2(MIN_BLOCK);
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int BLK_W    = LEVELS - 1;
  localparam int NBLK     = 1 << (LEVELS - 1);
  localparam int DEP_W    = LEVELS;
  localparam int FS_AW    = LEVELS;
  localparam int FS_DEPTH = (1 << LEVELS) - 1;
  localparam int REQ_W    = 16;
  localparam int ADDR_W   = 12;
  localparam int NEED_W   = REQ_W + 1;
  localparam int POOL_BYTES = MIN_BLOCK << (LEVELS - 1);

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_FREED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AL_CHECK,
    S_POP,
    S_POP_WAIT,
    S_POP_GOT,
    S_PUSH_HI,
    S_PUSH_LO,
    S_FR_CHECK,
    S_FR_LVL,
    S_MERGE,
    S_SCAN,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TAKEN,
    S_PUSH_FINAL
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } bba_res_t;

  // first stack entry of a level
  function automatic logic [FS_AW-1:0] lvl_base(input logic [LVL_W-1:0] l);
    lvl_base = (FS_AW'(1) << (LEVELS - 1 - int'(l))) - FS_AW'(1);
  endfunction

  function automatic logic [DEP_W-1:0] lvl_cap(input logic [LVL_W-1:0] l);
    lvl_cap = DEP_W'(1) << (LEVELS - 1 - int'(l));
  endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bba_engine.sv =====
// Sequencer and datapath: split, grant, buddy search and merge over the free stacks.
module bba_engine import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0] block_address,
  input  logic              res_ready,
  output logic              busy,
  output logic              res_valid,
  output bba_res_t          res
);

  localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

  state_t state, state_next;

  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  f;
  logic [BLK_W-1:0]  blk;
  logic [DEP_W-1:0]  idx;
  logic [DEP_W-1:0]  depth [LEVELS];
  logic [BLK_W-1:0]  top_ent;
  logic [NBLK-1:0]   gvalid;

  logic              fs_we;
  logic [FS_AW-1:0]  fs_waddr;
  logic [BLK_W-1:0]  fs_wdata;
  logic [FS_AW-1:0]  fs_raddr;
  logic [BLK_W-1:0]  fs_rdata;
  logic              gl_we;
  logic [LVL_W-1:0]  gl_rdata;

  logic [NEED_W-1:0] need;
  logic [LVL_W-1:0]  need_lvl;
  logic              alloc_fail;
  logic [LVL_W-1:0]  f_sel;
  logic              f_found;
  logic [ADDR_W-1:0] off;
  logic [BLK_W-1:0]  fblk;
  logic              free_bad;
  logic [BLK_W-1:0]  bud;
  logic [DEP_W-1:0]  dl;
  logic [DEP_W-1:0]  df;

  bba_ram #(.WIDTH(BLK_W), .DEPTH(FS_DEPTH)) u_fs_ram (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  bba_ram #(.WIDTH(LVL_W), .DEPTH(NBLK)) u_gl_ram (
    .clk(clk), .we(gl_we), .waddr(blk), .wdata(lvl),
    .raddr(fblk), .rdata(gl_rdata)
  );

  assign dl  = depth[lvl];
  assign df  = depth[f];
  assign bud = blk ^ (BLK_W'(1) << lvl);

  // request sizing and level search
  always_comb begin
    need     = NEED_W'(req_r) + NEED_W'(HEADER_BYTES);
    need_lvl = '0;
    for (int l = 0; l < LEVELS - 1; l++) begin
      if (NEED_W'(MIN_BLOCK << l) < need) begin
        need_lvl = need_lvl + LVL_W'(1);
      end
    end
    alloc_fail = (req_r == '0) || (need > NEED_W'(POOL_BYTES));
    f_sel   = '0;
    f_found = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (LVL_W'(l) >= need_lvl && depth[l] != '0) begin
        f_sel   = LVL_W'(l);
        f_found = 1'b1;
      end
    end
  end

  always_comb begin
    off      = addr_r - ADDR_W'(HEADER_BYTES);
    fblk     = BLK_W'(off >> MB_SH);
    free_bad = (addr_r < ADDR_W'(HEADER_BYTES)) || (off[MB_SH-1:0] != '0) ||
               ((off >> MB_SH) >= ADDR_W'(NBLK));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (start) state_next = (kind == KIND_FREE) ? S_FR_CHECK : S_AL_CHECK;
      S_AL_CHECK:   state_next = (alloc_fail || !f_found) ? S_IDLE : S_POP;
      S_POP:        state_next = (f == TOP) ? S_POP_GOT : S_POP_WAIT;
      S_POP_WAIT:   state_next = S_POP_GOT;
      S_POP_GOT:    state_next = (f > lvl) ? S_PUSH_HI : S_IDLE;
      S_PUSH_HI:    state_next = S_PUSH_LO;
      S_PUSH_LO:    state_next = S_POP;
      S_FR_CHECK:   state_next = (free_bad || !gvalid[fblk]) ? S_IDLE : S_FR_LVL;
      S_FR_LVL:     state_next = S_MERGE;
      S_MERGE:      state_next = (lvl == TOP) ? S_PUSH_FINAL : S_SCAN;
      S_SCAN:       state_next = (idx == dl) ? S_PUSH_FINAL : S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (fs_rdata == bud) begin
          state_next = (idx + DEP_W'(1) < dl) ? S_SHIFT_RD : S_TAKEN;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SHIFT_RD:   state_next = S_SHIFT_WR;
      S_SHIFT_WR:   state_next = (idx + DEP_W'(2) < dl) ? S_SHIFT_RD : S_TAKEN;
      S_TAKEN:      state_next = S_MERGE;
      S_PUSH_FINAL: state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
    // result waits in the idle state until the output side takes it
    if (state == S_IDLE && res_valid) begin
      state_next = res_ready ? (start ? state_next : S_IDLE) : S_IDLE;
    end
  end

  // memory controls
  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = '0;
    fs_wdata = '0;
    fs_raddr = '0;
    gl_we    = 1'b0;
    unique case (state)
      S_POP:      fs_raddr = lvl_base(f) + df - FS_AW'(1);
      S_SCAN:     fs_raddr = lvl_base(lvl) + idx;
      S_SHIFT_RD: fs_raddr = lvl_base(lvl) + idx + FS_AW'(1);
      S_SHIFT_WR: begin
        fs_we    = 1'b1;
        fs_waddr = lvl_base(lvl) + idx;
        fs_wdata = fs_rdata;
      end
      S_PUSH_HI: begin
        fs_we    = df < lvl_cap(f);
        fs_waddr = lvl_base(f) + df;
        fs_wdata = blk + (BLK_W'(1) << f);
      end
      S_PUSH_LO: begin
        fs_we    = df < lvl_cap(f);
        fs_waddr = lvl_base(f) + df;
        fs_wdata = blk;
      end
      S_PUSH_FINAL: begin
        fs_we    = (lvl != TOP) && (dl < lvl_cap(lvl));
        fs_waddr = lvl_base(lvl) + dl;
        fs_wdata = blk;
      end
      S_POP_GOT:  gl_we = (f == lvl);
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE) || (res_valid && !res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      gvalid    <= '0;
      top_ent   <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        depth[l] <= (l == LEVELS - 1) ? DEP_W'(1) : '0;
      end
    end else begin
      state <= state_next;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            req_r  <= request_bytes;
            addr_r <= block_address;
          end
        end
        S_AL_CHECK: begin
          lvl <= need_lvl;
          f   <= f_sel;
          if (alloc_fail || !f_found) begin
            res       <= '{addr: '0, status: ST_FAIL};
            res_valid <= 1'b1;
          end
        end
        S_POP: begin
          depth[f] <= df - DEP_W'(1);
          if (f == TOP) begin
            blk <= top_ent;
          end
        end
        S_POP_WAIT: blk <= fs_rdata;
        S_POP_GOT: begin
          if (f > lvl) begin
            f <= f - LVL_W'(1);
          end else begin
            gvalid[blk] <= 1'b1;
            res         <= '{addr: (ADDR_W'(blk) << MB_SH) + ADDR_W'(HEADER_BYTES),
                             status: ST_OK};
            res_valid   <= 1'b1;
          end
        end
        S_PUSH_HI, S_PUSH_LO: begin
          if (df < lvl_cap(f)) begin
            depth[f] <= df + DEP_W'(1);
          end
        end
        S_FR_CHECK: begin
          blk <= fblk;
          if (free_bad || !gvalid[fblk]) begin
            res       <= '{addr: '0, status: ST_FAIL};
            res_valid <= 1'b1;
          end else begin
            gvalid[fblk] <= 1'b0;
          end
        end
        S_FR_LVL:   lvl <= gl_rdata;
        S_MERGE:    idx <= '0;
        S_SCAN_CMP: if (fs_rdata != bud) idx <= idx + DEP_W'(1);
        S_SHIFT_WR: idx <= idx + DEP_W'(1);
        S_TAKEN: begin
          depth[lvl] <= dl - DEP_W'(1);
          if (bud < blk) begin
            blk <= bud;
          end
          lvl <= lvl + LVL_W'(1);
        end
        S_PUSH_FINAL: begin
          if (lvl == TOP) begin
            if (dl == '0) begin
              top_ent    <= blk;
              depth[lvl] <= DEP_W'(1);
            end
          end else if (dl < lvl_cap(lvl)) begin
            depth[lvl] <= dl + DEP_W'(1);
          end
          res       <= '{addr: '0, status: ST_FREED};
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator top level: input handshake, result register, checks.
// Steps: an allocate splits the found block a level at a time, pushing both halves, down
// to the needed level, or grants it whole; a free scans the level's stack for the buddy,
// shifts later entries down over it and merges upward; a refused item fails at its check.
// Throughput: one item at a time; the next beat is taken once the result has left the engine.
// Reset (synchronous, active high): whole pool free as one top-level block.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0] block_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] granted_address,
  output logic [1:0]        status
);

  logic     busy;
  logic     res_valid;
  logic     res_ready;
  logic     start;
  bba_res_t res;
  bba_res_t out_r;

  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign res_ready = !out_valid || !out_stall;

  bba_engine u_engine (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .request_bytes(request_bytes), .block_address(block_address),
    .res_ready(res_ready), .busy(busy), .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign granted_address = out_r.addr;
  assign status          = out_r.status;

  `BBA_ASSERT_NEXT(a_busy_after_accept, start, in_stall)
  `BBA_ASSERT_NEXT(a_result_moves_out, res_valid && res_ready, out_valid)
  `BBA_ASSERT_NOW(a_freed_zero_addr, out_valid && status == ST_FREED, granted_address == '0)
  `BBA_ASSERT_NOW(a_fail_zero_addr, out_valid && status == ST_FAIL, granted_address == '0)

endmodule
